### rtl/rlsfr_pkg.sv
// ----------------------------------------------------------------------------
// rlsfr_pkg: shared types and constants for the LED strip frame refresher
// Field widths of requests and results, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package rlsfr_pkg;

   localparam int OP_W        = 2;
   localparam int IDX_FIELD_W = 8;
   localparam int COLOR_W     = 8;
   localparam int WORD_W      = 3 * COLOR_W;
   localparam int LED_COUNT_W = 6;

   // No single pass emits more than this many words.
   localparam int PASS_CAP = 32;
   localparam int CNT_W    = $clog2(PASS_CAP + 1);

   typedef enum logic [OP_W-1:0] {
      OP_SET     = 2'd0,
      OP_REFRESH = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ZERO,
      ST_AGAIN,
      ST_READ
   } state_type;

endpackage

### rtl/rlsfr_ifs.sv
// ----------------------------------------------------------------------------
// rlsfr_ifs: request and response channels of the LED strip frame refresher
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
interface rlsfr_req_if;
   logic                                valid;
   logic                                ready;
   logic [rlsfr_pkg::OP_W-1:0]          op;
   logic [rlsfr_pkg::IDX_FIELD_W-1:0]   led_index;
   logic [rlsfr_pkg::COLOR_W-1:0]       red;
   logic [rlsfr_pkg::COLOR_W-1:0]       green;
   logic [rlsfr_pkg::COLOR_W-1:0]       blue;

   modport source (output valid, op, led_index, red, green, blue, input ready);
   modport sink   (input valid, op, led_index, red, green, blue, output ready);
endinterface

interface rlsfr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rlsfr_pkg::WORD_W-1:0]        pixel_word;
   logic                                last_pixel;

   modport source (output valid, pixel_word, last_pixel, input ready);
   modport sink   (input valid, pixel_word, last_pixel, output ready);
endinterface

### rtl/rlsfr_store.sv
// ----------------------------------------------------------------------------
// rlsfr_store: pixel memory with one write and one registered read port
// Per-entry valid bits make every entry read as zero until written.
// ----------------------------------------------------------------------------
module rlsfr_store #(
   parameter int MAX_LEDS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] wr_addr,
   input  logic [rlsfr_pkg::WORD_W-1:0]  wr_data,
   input  logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] rd_addr,
   output logic [rlsfr_pkg::WORD_W-1:0]  rd_word
);

   logic [rlsfr_pkg::WORD_W-1:0] store_mem [MAX_LEDS];
   logic [MAX_LEDS-1:0]          valid_ff;
   logic [MAX_LEDS-1:0]          valid_in;
   logic [rlsfr_pkg::WORD_W-1:0] rd_data_ff;
   logic                         rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

endmodule

### rtl/rlsfr_seq.sv
// ----------------------------------------------------------------------------
// rlsfr_seq: request decoder, pass sequencer and output register
// One shared pixel counter walks the store for zero and refresh passes.
// ----------------------------------------------------------------------------
module rlsfr_seq #(
   parameter int MAX_LEDS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   rlsfr_req_if.sink                         req,
   rlsfr_rsp_if.source                       rsp,
   input  logic [rlsfr_pkg::CNT_W-1:0]       pass_len,
   output logic                              wr_en,
   output logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] wr_addr,
   output logic [rlsfr_pkg::WORD_W-1:0]      wr_data,
   output logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] rd_addr,
   input  logic [rlsfr_pkg::WORD_W-1:0]      rd_word
);

   localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int AW    = (IDX_W > rlsfr_pkg::CNT_W) ? IDX_W : rlsfr_pkg::CNT_W;
   localparam int CMP_W = rlsfr_pkg::IDX_FIELD_W + 1;

   rlsfr_pkg::state_type          state_ff, state_in;
   logic [rlsfr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                          dirty_ff, dirty_in;
   logic                          out_valid_ff, out_valid_in;
   logic [rlsfr_pkg::WORD_W-1:0]  out_word_ff, out_word_in;
   logic                          out_last_ff, out_last_in;

   logic                          slot_free;
   logic                          is_last;
   logic                          in_range;
   logic [AW-1:0]                 cnt_wide;
   logic [AW-1:0]                 rd_wide;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign is_last   = (cnt_ff + rlsfr_pkg::CNT_W'(1)) == pass_len;
   assign in_range  = {1'b0, req.led_index} < CMP_W'(MAX_LEDS);
   assign cnt_wide  = AW'(cnt_ff);
   assign rd_wide   = AW'(cnt_in);
   assign rd_addr   = rd_wide[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dirty_in     = dirty_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_wide[IDX_W-1:0];
      wr_data      = '0;
      req.ready    = (state_ff == rlsfr_pkg::ST_IDLE);

      case (state_ff)
         rlsfr_pkg::ST_IDLE: begin
            if (req.valid) begin
               case (rlsfr_pkg::op_type'(req.op))
                  rlsfr_pkg::OP_SET: begin
                     if (in_range) begin
                        wr_en    = 1'b1;
                        wr_addr  = req.led_index[IDX_W-1:0];
                        wr_data  = {req.red, req.green, req.blue};
                        dirty_in = 1'b1;
                     end
                  end
                  rlsfr_pkg::OP_REFRESH: begin
                     dirty_in = 1'b0;
                     if (dirty_ff && (pass_len != '0)) begin
                        state_in = rlsfr_pkg::ST_READ;
                        cnt_in   = '0;
                     end
                  end
                  rlsfr_pkg::OP_CLEAR: begin
                     // The trailing refresh of a clear always leaves the frame clean.
                     dirty_in = 1'b0;
                     if (pass_len != '0) begin
                        state_in = rlsfr_pkg::ST_ZERO;
                        cnt_in   = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         rlsfr_pkg::ST_ZERO: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_word_in  = '0;
               out_last_in  = is_last;
               wr_en        = 1'b1;
               cnt_in       = is_last ? '0 : cnt_ff + rlsfr_pkg::CNT_W'(1);
               if (is_last) begin
                  state_in = rlsfr_pkg::ST_AGAIN;
               end
            end
         end
         rlsfr_pkg::ST_AGAIN: begin
            // The refresh after a clear sends entries that were just zeroed.
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_word_in  = '0;
               out_last_in  = is_last;
               cnt_in       = is_last ? '0 : cnt_ff + rlsfr_pkg::CNT_W'(1);
               if (is_last) begin
                  state_in = rlsfr_pkg::ST_IDLE;
               end
            end
         end
         rlsfr_pkg::ST_READ: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_word_in  = rd_word;
               out_last_in  = is_last;
               cnt_in       = is_last ? '0 : cnt_ff + rlsfr_pkg::CNT_W'(1);
               if (is_last) begin
                  state_in = rlsfr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rlsfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlsfr_pkg::ST_IDLE;
         cnt_ff       <= '0;
         dirty_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dirty_ff     <= dirty_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.pixel_word = out_word_ff;
   assign rsp.last_pixel = out_last_ff;

endmodule

### rtl/rgb_led_strip_frame_refresher.sv
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_refresher: pixel store and frame refresher
// Stores colour triples for an RGB LED strip and streams them out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   req_bus   in          op, led_index, red, green, blue
//   rsp_bus   out         pixel_word (red, green, blue), last_pixel
//   csr_*     in          led_count (write only)
//
// A refresh of a dirty frame emits one word per cycle while the response side
// takes them, the first store read being issued as the request is accepted;
// a clear emits N zero words while zeroing the store, then N zero words more,
// N being led_count limited to the store size and to 32.
// Reset is synchronous; it clears the sequencer, the dirty mark, led_count and
// the valid bits of the store, so unwritten pixels read as zero at once.
// When the response side stalls, the output register holds its word and the
// pass simply waits; requests are refused until the pass has finished.
//
module rgb_led_strip_frame_refresher #(
   parameter int MAX_LEDS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rlsfr_req_if.sink                            req_bus,
   rlsfr_rsp_if.source                          rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [rlsfr_pkg::LED_COUNT_W-1:0]    csr_wr_data
);

   localparam int IDX_W    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   // Longest pass: the store size, but never more than the pass cap.
   localparam int PASS_MAX = (MAX_LEDS < rlsfr_pkg::PASS_CAP) ? MAX_LEDS
                                                             : rlsfr_pkg::PASS_CAP;

   logic [rlsfr_pkg::LED_COUNT_W-1:0] led_count_ff;
   logic [rlsfr_pkg::LED_COUNT_W-1:0] led_count_in;
   logic [rlsfr_pkg::CNT_W-1:0]       pass_len;

   logic                              wr_en;
   logic [IDX_W-1:0]                  wr_addr;
   logic [rlsfr_pkg::WORD_W-1:0]      wr_data;
   logic [IDX_W-1:0]                  rd_addr;
   logic [rlsfr_pkg::WORD_W-1:0]      rd_word;

   // Write the count register only while no pass is running; nothing enforces it.
   assign led_count_in = csr_wr_en ? csr_wr_data : led_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= '0;
      end else begin
         led_count_ff <= led_count_in;
      end
   end

   // Saturate the programmed count to the longest pass, PASS_MAX.
   always_comb begin
      if (led_count_ff > rlsfr_pkg::LED_COUNT_W'(PASS_MAX)) begin
         pass_len = rlsfr_pkg::CNT_W'(PASS_MAX);
      end else begin
         pass_len = rlsfr_pkg::CNT_W'(led_count_ff);
      end
   end

   rlsfr_seq #(
      .MAX_LEDS (MAX_LEDS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .pass_len (pass_len),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_word  (rd_word)
   );

   rlsfr_store #(
      .MAX_LEDS (MAX_LEDS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_word  (rd_word)
   );

endmodule
